### design/bresenham_line_rasterizer_core_macros.svh
// Assertion macros shared by the rasteriser modules.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blr: same-cycle check failed");

// Next-cycle implication.
`define BLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blr: next-cycle check failed");

`else

`define BLR_ASSERT_NOW(label, ante, cons)
`define BLR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/blr_pkg.sv
package blr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        span_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    typedef struct packed {
        logic   mode;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } request_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_point;
        logic   stale;
    } result_t;

    // Classified item passed from front end to stepper
    typedef struct packed {
        logic   mode;
        coord_t x0;
        coord_t y0;
        logic   dir_x;
        logic   dir_y;
        logic   x_major;
        span_t  major;
        span_t  minor;
    } cmd_t;

endpackage

### design/blr_front.sv
module blr_front
(
    input  blr_pkg::request_t request,
    output blr_pkg::cmd_t     cmd
);
    import blr_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] dx_neg;
    logic signed [COORD_BITS:0] dy_neg;
    span_t                      adx;
    span_t                      ady;
    logic                       x_major;

    assign dx     = {request.end_x[COORD_BITS-1], request.end_x}
                  - {request.start_x[COORD_BITS-1], request.start_x};
    assign dy     = {request.end_y[COORD_BITS-1], request.end_y}
                  - {request.start_y[COORD_BITS-1], request.start_y};
    assign dx_neg = -dx;
    assign dy_neg = -dy;

    // magnitude always fits COORD_BITS unsigned
    assign adx = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    // x is major only on a strict win
    assign x_major = (adx > ady);

    always_comb
    begin
        cmd.mode    = request.mode;
        cmd.x0      = request.start_x;
        cmd.y0      = request.start_y;
        // -1 unless end lies strictly above start
        cmd.dir_x   = dx[COORD_BITS] || (dx == '0);
        cmd.dir_y   = dy[COORD_BITS] || (dy == '0);
        cmd.x_major = x_major;
        cmd.major   = x_major ? adx : ady;
        cmd.minor   = x_major ? ady : adx;
    end

endmodule

### design/blr_cmd_queue.sv
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_cmd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  blr_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          take,
    output logic          valid,
    output blr_pkg::cmd_t rd_cmd
);
    import blr_pkg::*;

    cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full   = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign rd_cmd = slot_reg[rd_ptr_reg];
    assign do_wr  = push && !full;
    assign do_rd  = take && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    `BLR_ASSERT_NOW(a_q_no_overfill, 1'b1, count_reg <= QCNT_BITS'(QUEUE_DEPTH))
    `BLR_ASSERT_NEXT(a_q_fill_counts, do_wr && !do_rd, count_reg == $past(count_reg) + 1'b1)
    `BLR_ASSERT_NEXT(a_q_drain_counts, do_rd && !do_wr, count_reg == $past(count_reg) - 1'b1)

endmodule

### design/blr_stepper.sv
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_stepper
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  blr_pkg::cmd_t    cmd,
    output logic             take,
    output blr_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import blr_pkg::*;

    coord_t  cur_x_reg;
    coord_t  cur_x_next;
    coord_t  cur_y_reg;
    coord_t  cur_y_next;
    err_t    err_reg;
    err_t    err_next;
    err_t    inc_nonneg_reg;
    err_t    inc_nonneg_next;
    err_t    inc_neg_reg;
    err_t    inc_neg_next;
    logic    dir_x_reg;
    logic    dir_x_next;
    logic    dir_y_reg;
    logic    dir_y_next;
    logic    x_major_reg;
    logic    x_major_next;
    span_t   steps_reg;
    span_t   steps_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    err_t    minor2;
    err_t    major1;
    err_t    major2;
    coord_t  step_x;
    coord_t  step_y;
    coord_t  x_adv;
    coord_t  y_adv;
    logic    minor_move;

    // free output slot or one leaving this cycle
    assign take   = cmd_valid && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    assign minor2 = {{(ERR_BITS-COORD_BITS-1){1'b0}}, cmd.minor, 1'b0};
    assign major1 = {{(ERR_BITS-COORD_BITS){1'b0}}, cmd.major};
    assign major2 = {{(ERR_BITS-COORD_BITS-1){1'b0}}, cmd.major, 1'b0};

    assign step_x     = dir_x_reg ? '1 : COORD_BITS'(1);
    assign step_y     = dir_y_reg ? '1 : COORD_BITS'(1);
    assign x_adv      = cur_x_reg + step_x;
    assign y_adv      = cur_y_reg + step_y;
    assign minor_move = !err_reg[ERR_BITS-1];

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_next        = err_reg;
        inc_nonneg_next = inc_nonneg_reg;
        inc_neg_next    = inc_neg_reg;
        dir_x_next      = dir_x_reg;
        dir_y_next      = dir_y_reg;
        x_major_next    = x_major_reg;
        steps_next      = steps_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pop;

        if (take)
        begin
            out_valid_next = 1'b1;
            if (cmd.mode == MODE_START)
            begin
                cur_x_next          = cmd.x0;
                cur_y_next          = cmd.y0;
                err_next            = minor2 - major1;
                inc_nonneg_next     = minor2 - major2;
                inc_neg_next        = minor2;
                dir_x_next          = cmd.dir_x;
                dir_y_next          = cmd.dir_y;
                x_major_next        = cmd.x_major;
                steps_next          = cmd.major;
                out_next.pixel_x    = cmd.x0;
                out_next.pixel_y    = cmd.y0;
                out_next.last_point = (cmd.major == '0);
                out_next.stale      = 1'b0;
            end
            else if (steps_reg == '0)
            begin
                // line already finished: repeat end pixel
                out_next.pixel_x    = cur_x_reg;
                out_next.pixel_y    = cur_y_reg;
                out_next.last_point = 1'b1;
                out_next.stale      = 1'b1;
            end
            else
            begin
                if (x_major_reg)
                begin
                    cur_x_next = x_adv;
                    cur_y_next = minor_move ? y_adv : cur_y_reg;
                end
                else
                begin
                    cur_y_next = y_adv;
                    cur_x_next = minor_move ? x_adv : cur_x_reg;
                end
                err_next            = err_reg + (minor_move ? inc_nonneg_reg : inc_neg_reg);
                steps_next          = steps_reg - 1'b1;
                out_next.pixel_x    = cur_x_next;
                out_next.pixel_y    = cur_y_next;
                out_next.last_point = (steps_reg == COORD_BITS'(1));
                out_next.stale      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            err_reg        <= '0;
            inc_nonneg_reg <= '0;
            inc_neg_reg    <= '0;
            dir_x_reg      <= 1'b0;
            dir_y_reg      <= 1'b0;
            x_major_reg    <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            err_reg        <= err_next;
            inc_nonneg_reg <= inc_nonneg_next;
            inc_neg_reg    <= inc_neg_next;
            dir_x_reg      <= dir_x_next;
            dir_y_reg      <= dir_y_next;
            x_major_reg    <= x_major_next;
            steps_reg      <= steps_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `BLR_ASSERT_NOW(a_stale_is_last, !empty && result.stale, result.last_point)
    `BLR_ASSERT_NEXT(a_final_step, take && cmd.mode == MODE_STEP && steps_reg == COORD_BITS'(1), steps_reg == '0 && result.last_point && !result.stale)
    `BLR_ASSERT_NEXT(a_point_line, take && cmd.mode == MODE_START && cmd.major == '0, result.last_point && !result.stale && steps_reg == '0)

endmodule

### design/bresenham_line_rasterizer_core.sv
// An item passes the command queue slot and then the result register on its way to the ports.
// Throughput: one item per clock while results pop; the error add-and-compare is the loop.
// A two-entry command queue lets the front end accept while the stepper or result stalls.
// Reset (rst_n low, asynchronous) empties queue and result slot and zeroes the walk state,
// so a step straight after reset returns pixel (0,0) flagged last and stale.
module bresenham_line_rasterizer_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  blr_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output blr_pkg::result_t  result
);
    import blr_pkg::*;

    cmd_t front_cmd;   // classified item from the front end
    cmd_t queue_cmd;   // oldest queued item
    logic queue_valid;
    logic step_take;   // stepper consumes the queue head

    // Front end: endpoint deltas, directions and major/minor split.
    blr_front u_front
    (
        .request (request),
        .cmd     (front_cmd)
    );

    // Decoupling queue; full is purely registered.
    blr_cmd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .full   (full),
        .take   (step_take),
        .valid  (queue_valid),
        .rd_cmd (queue_cmd)
    );

    // Back end: Bresenham walk and the result register.
    blr_stepper u_stepper
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .take      (step_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
